[hw/rtl/pee_pkg.sv]
`default_nettype none
package pee_pkg;

  // expression characters
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  localparam logic [31:0] DIGIT_BASE  = 32'd48;
  localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FC19;  // -999

  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } pee_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         depth;
    logic               div_by_zero;
    logic               stack_overflow;
  } pee_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic digit;
    logic push_acc;
    logic rd_second;
    logic take_a;
    logic take_b;
    logic exec;
    logic div_step;
    logic div_fix;
    logic push_res;
    logic load_out;
  } pee_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_op;
    logic is_div;
    logic is_at;
    logic last;
    logic a_zero;
    logic div_last;
    logic out_full;
  } pee_stat_t;

endpackage
`default_nettype wire

[hw/rtl/pee_ctrl.sv]
`default_nettype none
module pee_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pee_pkg::pee_stat_t stat,
  output pee_pkg::pee_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDB    = 4'd2;
  localparam logic [3:0] S_OPB    = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DFIX   = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;
  localparam logic [3:0] S_TOP    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        // top of stack is read here for an operator
        if (stat.is_op) begin
          state_nxt = S_RDB;
        end else begin
          if (stat.is_at) begin
            cmd.push_acc = 1'b1;
          end else begin
            cmd.digit = 1'b1;
          end
          state_nxt = stat.last ? S_TOP : S_IDLE;
        end
      end
      S_RDB: begin
        cmd.take_a    = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_OPB;
      end
      S_OPB: begin
        cmd.take_b = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.is_div && !stat.a_zero) ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DFIX;
        end
      end
      S_DFIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt    = stat.last ? S_TOP : S_IDLE;
      end
      S_TOP: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pee_dpath.sv]
`default_nettype none
module pee_dpath #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pee_pkg::pee_in_t   in_data,
  input  wire pee_pkg::pee_cmd_t  cmd,
  output pee_pkg::pee_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pee_pkg::pee_out_t       out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic [31:0]           mem [STACK_DEPTH];
  logic [31:0]           rdata_r;
  logic [AW-1:0]         raddr;

  logic [7:0]            ch_r;
  logic                  last_r;
  logic [CW-1:0]         count_r;
  logic [31:0]           acc_r;
  logic [31:0]           acc_nxt;
  logic                  dz_r;
  logic                  ovf_r;
  logic [31:0]           a_r;
  logic [31:0]           b_r;
  logic [31:0]           res_r;

  logic [31:0]           quo_r;
  logic [31:0]           rem_r;
  logic [31:0]           dvsr_r;
  logic                  neg_r;
  logic [pee_pkg::DIV_CW-1:0] dcnt_r;
  logic [32:0]           rem_shift;
  logic [32:0]           rem_diff;

  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         cnt_m2;
  logic [CW-1:0]         push_base;
  logic [31:0]           push_data;
  logic                  push_en;

  pee_pkg::pee_out_t     out_r;
  logic                  out_valid_r;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);
  assign raddr  = cmd.rd_second ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

  assign stat.is_op    = (ch_r == pee_pkg::CH_PLUS) || (ch_r == pee_pkg::CH_MINUS) ||
                         (ch_r == pee_pkg::CH_MUL)  || (ch_r == pee_pkg::CH_DIV);
  assign stat.is_div   = (ch_r == pee_pkg::CH_DIV);
  assign stat.is_at    = (ch_r == pee_pkg::CH_AT);
  assign stat.last     = last_r;
  assign stat.a_zero   = (a_r == 32'd0);
  assign stat.div_last = (dcnt_r == pee_pkg::DIV_CW'(pee_pkg::DIV_STEPS - 1));
  assign stat.out_full = out_valid_r && !out_ready;

  // acc * 10 as two shifted copies
  assign acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, ch_r} - pee_pkg::DIGIT_BASE;

  // an operator pops two (floored at empty) before pushing
  assign push_base = cmd.push_acc ? count_r :
                     ((count_r >= CW'(2)) ? cnt_m2 : '0);
  assign push_data = cmd.push_acc ? acc_r : res_r;
  assign push_en   = cmd.push_acc || cmd.push_res;

  // restoring divider, one quotient bit a cycle
  assign rem_shift = {rem_r, quo_r[31]};
  assign rem_diff  = rem_shift - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (push_en && (push_base < FULL_COUNT)) begin
      mem[push_base[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r   <= in_data.character;
      last_r <= in_data.last_char;
    end
    if (cmd.take_a) begin
      a_r <= (count_r != '0) ? rdata_r : pee_pkg::EMPTY_VALUE;
    end
    if (cmd.take_b) begin
      b_r <= (count_r >= CW'(2)) ? rdata_r : pee_pkg::EMPTY_VALUE;
    end
    if (cmd.exec) begin
      case (ch_r)
        pee_pkg::CH_PLUS:  res_r <= b_r + a_r;
        pee_pkg::CH_MINUS: res_r <= b_r - a_r;
        pee_pkg::CH_MUL:   res_r <= b_r * a_r;
        default:           res_r <= '0;
      endcase
      quo_r  <= b_r[31] ? (32'd0 - b_r) : b_r;
      dvsr_r <= a_r[31] ? (32'd0 - a_r) : a_r;
      rem_r  <= '0;
      neg_r  <= a_r[31] ^ b_r[31];
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + pee_pkg::DIV_CW'(1);
      // remainder stays below the divisor, so 32 bits hold it
      if (!rem_diff[32]) begin
        rem_r <= rem_diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_shift[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      res_r <= neg_r ? (32'd0 - quo_r) : quo_r;
    end
    if (cmd.load_out) begin
      out_r.value          <= (count_r != '0) ? rdata_r : pee_pkg::EMPTY_VALUE;
      out_r.depth          <= 6'(count_r);
      out_r.div_by_zero    <= dz_r;
      out_r.stack_overflow <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      acc_r       <= '0;
      dz_r        <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        // result leaves, expression state starts over
        count_r     <= '0;
        acc_r       <= '0;
        dz_r        <= 1'b0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        if (cmd.digit) begin
          acc_r <= acc_nxt;
        end
        if (cmd.push_acc) begin
          acc_r <= '0;
        end
        if (cmd.exec && stat.is_div && stat.a_zero) begin
          dz_r <= 1'b1;
        end
        if (push_en) begin
          if (push_base < FULL_COUNT) begin
            count_r <= push_base + CW'(1);
          end else begin
            count_r <= push_base;
            ovf_r   <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hw/rtl/postfix_expression_evaluator.sv]
`default_nettype none
// Postfix (RPN) evaluator fed one character word at a time: digits build a number,
// '@' pushes it, '+' '-' '*' '/' pop two operands and push the 32-bit wrapped
// result (division truncates toward zero, divide by zero gives 0 and a sticky
// flag, a push onto a full stack is dropped with a sticky flag, a pop from an
// empty stack gives -999). A word marked last_char produces one result word with
// the top of stack (-999 if empty), the depth modulo 64 and both flags, then the
// evaluator clears itself. The operand stack is a memory with one read port and one
// write port and a registered read, so operands come out one per cycle. Digit and
// '@' words are applied at decode; '+' '-' '*' read both operands, execute and push;
// '/' also runs the bit-serial divider, one quotient bit per cycle, and a sign fix;
// a last word adds the top-of-stack read and waits while the output register is full.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pee_pkg::pee_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pee_pkg::pee_out_t      out_data
);

  pee_pkg::pee_cmd_t  cmd;
  pee_pkg::pee_stat_t stat;

  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pee_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
